// ----- hw/rtl/robin_hood_hash_table_assert.svh -----
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Short forms for the clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, idle during reset.
`define RHH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("robin hood hash table check failed");

// Next-cycle implication, sampled on aclk, idle during reset.
`define RHH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("robin hood hash table check failed");

`endif

// ----- hw/rtl/rhh_pkg.sv -----
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Fixed widths, request codes and status codes shared by the block files.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int DIST_W      = 10;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CNT_W-1:0] MIN_SIZE = CNT_W'(2);
    localparam logic [CNT_W-1:0] MAX_SIZE = CNT_W'(TABLE_DEPTH);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

// ----- hw/rtl/robin_hood_hash_table.sv -----
// Sequence: an ignored, out-of-range or table-full request goes straight to the result
// state; any other request reads, then evaluates, each probed slot, and a remove then
// reads and evaluates each slot examined by the back-shift, the emptied one included.
// One request at a time: the next is taken only once its result register is loaded,
// which waits while an earlier result is still held. Reset (aresetn, synchronous,
// low) and every table_size write start a clearing pass over all slots that blocks requests.
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressed table with linear probing, Robin Hood placement on insert,
// early-exit lookup and back-shift removal, walked one slot at a time.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
    parameter int TAG_WIDTH   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration channel: table_size.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rhh_pkg::CNT_W-1:0]     cfg_data,
    // Request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rhh_pkg::REQ_W-1:0]     s_req_type,
    input  logic [rhh_pkg::IDX_W-1:0]     s_home_index,
    input  logic [TAG_WIDTH-1:0]          s_tag,
    input  logic [VALUE_WIDTH-1:0]        s_new_value,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhh_pkg::STATUS_W-1:0]  m_status,
    output logic [VALUE_WIDTH-1:0]        m_found_value,
    output logic [rhh_pkg::CNT_W-1:0]     m_probe_count,
    output logic [rhh_pkg::CNT_W-1:0]     m_entry_count
);
    import rhh_pkg::*;

    // Each memory word holds, from the top: valid, distance, tag, value.
    localparam int VAL_LSB  = 0;
    localparam int TAG_LSB  = VALUE_WIDTH;
    localparam int DIST_LSB = VALUE_WIDTH + TAG_WIDTH;
    localparam int VLD_BIT  = VALUE_WIDTH + TAG_WIDTH + DIST_W;
    localparam int WORD_W   = VLD_BIT + 1;

    // The sequencer: a clearing pass, then requests walk the table through a
    // read state and an evaluate state; removal adds a shift read/evaluate pair.
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_EV    = 7'b0001000,
        S_SHRD  = 7'b0010000,
        S_SHEV  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      size_reg, size_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [DIST_W-1:0]     cd_reg, cd_next;
    logic [CNT_W-1:0]      probe_reg, probe_next;
    logic [CNT_W-1:0]      shcnt_reg, shcnt_next;
    logic [TAG_WIDTH-1:0]  ct_reg, ct_next;
    logic [VALUE_WIDTH-1:0] cv_reg, cv_next;
    logic [REQ_W-1:0]      op_reg, op_next;
    logic [STATUS_W-1:0]   rstat_reg, rstat_next;
    logic [VALUE_WIDTH-1:0] rfound_reg, rfound_next;
    logic                  mv_reg, mv_next;
    logic [STATUS_W-1:0]   ms_reg, ms_next;
    logic [VALUE_WIDTH-1:0] mf_reg, mf_next;
    logic [CNT_W-1:0]      mp_reg, mp_next;
    logic [CNT_W-1:0]      me_reg, me_next;

    // Slot memory with a registered read port.
    logic [WORD_W-1:0]     mem [TABLE_DEPTH];
    logic [WORD_W-1:0]     rd_reg;
    logic                  we;
    logic [IDX_W-1:0]      waddr, raddr;
    logic [WORD_W-1:0]     wdata;

    logic [CNT_W-1:0]      n_eff;
    logic                  rd_vld;
    logic [DIST_W-1:0]     rd_dist;
    logic [TAG_WIDTH-1:0]  rd_tag;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [IDX_W-1:0]      idx_adv, cur_adv;
    logic [CNT_W-1:0]      probe_inc;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] s;
        s = {1'b0, i} + CNT_W'(1);
        return (s >= n) ? '0 : s[IDX_W-1:0];
    endfunction

    // The size register is clamped to the range two to the table depth.
    assign n_eff = (size_reg < MIN_SIZE) ? MIN_SIZE :
                   (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;

    assign rd_vld  = rd_reg[VLD_BIT];
    assign rd_dist = rd_reg[DIST_LSB +: DIST_W];
    assign rd_tag  = rd_reg[TAG_LSB +: TAG_WIDTH];
    assign rd_val  = rd_reg[VAL_LSB +: VALUE_WIDTH];

    assign idx_adv   = wrap_next(idx_reg, n_eff);
    assign cur_adv   = wrap_next(cur_reg, n_eff);
    assign probe_inc = probe_reg + CNT_W'(1);

    // The shift pass reads the slot after the current one; everything else
    // reads the probe position.
    assign raddr = (state_reg == S_SHRD) ? cur_adv : idx_reg;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = mv_reg;
    assign m_status      = ms_reg;
    assign m_found_value = mf_reg;
    assign m_probe_count = mp_reg;
    assign m_entry_count = me_reg;

    always_comb begin
        state_next  = state_reg;
        size_next   = size_reg;
        occ_next    = occ_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        cd_next     = cd_reg;
        probe_next  = probe_reg;
        shcnt_next  = shcnt_reg;
        ct_next     = ct_reg;
        cv_next     = cv_reg;
        op_next     = op_reg;
        rstat_next  = rstat_reg;
        rfound_next = rfound_reg;
        mv_next     = mv_reg;
        ms_next     = ms_reg;
        mf_next     = mf_reg;
        mp_next     = mp_reg;
        me_next     = me_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = {1'b1, cd_reg, ct_reg, cv_reg};

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                // Every slot is written empty with distance zero.
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_req_type;
                    idx_next    = s_home_index;
                    ct_next     = s_tag;
                    cv_next     = s_new_value;
                    cd_next     = '0;
                    probe_next  = '0;
                    rstat_next  = ST_OK;
                    rfound_next = '0;
                    if (s_req_type == REQ_NONE) begin
                        state_next = S_RESP;
                    end else if ({1'b0, s_home_index} >= n_eff) begin
                        rstat_next = ST_RANGE;
                        state_next = S_RESP;
                    end else if (s_req_type == REQ_INSERT && occ_reg >= n_eff) begin
                        rstat_next = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                probe_next = probe_inc;
                if (op_reg == REQ_INSERT) begin
                    if (!rd_vld) begin
                        // Empty slot: the carried entry settles here.
                        we         = 1'b1;
                        occ_next   = occ_reg + CNT_W'(1);
                        state_next = S_RESP;
                    end else if (rd_dist < cd_reg) begin
                        // The resident is richer, so it swaps with the carried entry.
                        we      = 1'b1;
                        ct_next = rd_tag;
                        cv_next = rd_val;
                        cd_next = rd_dist + DIST_W'(1);
                    end else if (rd_tag == ct_reg) begin
                        we         = 1'b1;
                        wdata      = {1'b1, rd_dist, rd_tag, cv_reg};
                        state_next = S_RESP;
                    end else begin
                        cd_next = cd_reg + DIST_W'(1);
                    end
                    if (rd_vld && !(rd_dist >= cd_reg && rd_tag == ct_reg)) begin
                        if (probe_inc >= n_eff) begin
                            state_next = S_RESP;
                        end else begin
                            idx_next   = idx_adv;
                            state_next = S_RD;
                        end
                    end
                end else begin
                    // Lookup and remove share the search walk.
                    if (!rd_vld || rd_dist < cd_reg) begin
                        rstat_next = ST_NOT_FOUND;
                        state_next = S_RESP;
                    end else if (rd_tag == ct_reg) begin
                        if (op_reg == REQ_LOOKUP) begin
                            rfound_next = rd_val;
                            state_next  = S_RESP;
                        end else begin
                            cur_next   = idx_reg;
                            shcnt_next = '0;
                            state_next = S_SHRD;
                        end
                    end else if (probe_inc >= n_eff) begin
                        rstat_next = ST_NOT_FOUND;
                        state_next = S_RESP;
                    end else begin
                        cd_next    = cd_reg + DIST_W'(1);
                        idx_next   = idx_adv;
                        state_next = S_RD;
                    end
                end
            end
            S_SHRD: begin
                if (shcnt_reg + CNT_W'(1) >= n_eff) begin
                    we         = 1'b1;
                    waddr      = cur_reg;
                    wdata      = '0;
                    occ_next   = (occ_reg != '0) ? occ_reg - CNT_W'(1) : occ_reg;
                    state_next = S_RESP;
                end else begin
                    state_next = S_SHEV;
                end
            end
            S_SHEV: begin
                we    = 1'b1;
                waddr = cur_reg;
                if (!rd_vld || rd_dist == '0) begin
                    wdata      = '0;
                    occ_next   = (occ_reg != '0) ? occ_reg - CNT_W'(1) : occ_reg;
                    state_next = S_RESP;
                end else begin
                    wdata      = {1'b1, rd_dist - DIST_W'(1), rd_tag, rd_val};
                    cur_next   = cur_adv;
                    shcnt_next = shcnt_reg + CNT_W'(1);
                    state_next = S_SHRD;
                end
            end
            S_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = rstat_reg;
                    mf_next    = rfound_reg;
                    mp_next    = probe_reg;
                    me_next    = occ_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A size write empties the table and starts a fresh clearing pass.
        if (cfg_valid) begin
            size_next  = cfg_data;
            occ_next   = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            size_reg  <= MAX_SIZE;
            occ_reg   <= '0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
            occ_reg   <= occ_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        cd_reg     <= cd_next;
        probe_reg  <= probe_next;
        shcnt_reg  <= shcnt_next;
        ct_reg     <= ct_next;
        cv_reg     <= cv_next;
        op_reg     <= op_next;
        rstat_reg  <= rstat_next;
        rfound_reg <= rfound_next;
        ms_reg     <= ms_next;
        mf_reg     <= mf_next;
        mp_reg     <= mp_next;
        me_reg     <= me_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

endmodule

// ----- hw/rtl/rhh_checker.sv -----
// ----------------------------------------------------------------------------
// Robin Hood hash table checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "robin_hood_hash_table_assert.svh"

module rhh_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rhh_pkg::STATUS_W-1:0] m_status,
    input logic [VALUE_WIDTH-1:0]       m_found_value,
    input logic [rhh_pkg::CNT_W-1:0]    m_probe_count,
    input logic [rhh_pkg::CNT_W-1:0]    m_entry_count
);
    import rhh_pkg::*;

    `RHH_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid)
    `RHH_ASSERT_NEXT(a_busy_after_request, s_valid && s_ready, !s_ready)
    `RHH_ASSERT_NOW(a_no_probe_on_reject, m_valid && (m_status == ST_RANGE || m_status == ST_FULL), m_probe_count == '0)
    `RHH_ASSERT_NOW(a_value_only_on_ok, m_valid && m_status != ST_OK, m_found_value == '0)
    `RHH_ASSERT_NOW(a_count_bounded, m_valid, m_entry_count <= MAX_SIZE)

endmodule

bind robin_hood_hash_table rhh_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_rhh_checker (.*);
